>>> rtl/diff_drive_safety_controller_defines.svh
// assertion helpers for the drive controller
`ifndef DIFF_DRIVE_SAFETY_CONTROLLER_DEFINES_SVH
`define DIFF_DRIVE_SAFETY_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define DDSC_ASSERT_NOW(label, clk_s, rstn_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |-> (post)) \
        else $error("ddsc check failed");

// next-cycle implication
`define DDSC_ASSERT_NEXT(label, clk_s, rstn_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
        else $error("ddsc check failed");

`endif

>>> rtl/ddsc_pkg.sv
`timescale 1ns / 1ps

package ddsc_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int IN_TDATA_W     = 56;
    localparam int IN_TUSER_W     = 3;
    localparam int OUT_TDATA_W    = 104;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [14:0] STOP_ECHO_RESET = 15'd2040;
    localparam logic [15:0] WDOG_RESET      = 16'd750;
    localparam logic [15:0] SINCE_MAX       = 16'hFFFF;
    localparam logic signed [15:0] CMD_LIMIT = 16'sd100;

    // x / 100 == (x * 5243) >> 19 for x up to 25500
    localparam logic [12:0] DUTY_RECIP = 13'd5243;
    localparam int          DUTY_SHIFT = 19;

    typedef enum logic [2:0] {
        MODE_DRIVE = 3'd0,
        MODE_STOP  = 3'd1,
        MODE_CLEAR = 3'd2,
        MODE_TICK  = 3'd3,
        MODE_LEFT  = 3'd4,
        MODE_RIGHT = 3'd5,
        MODE_ECHO  = 3'd6
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_QUAD      = 3'd0,
        REG_LEFT_INV  = 3'd1,
        REG_RIGHT_INV = 3'd2,
        REG_BUMP_EN   = 3'd3,
        REG_US_EN     = 3'd4,
        REG_STOP_ECHO = 3'd5,
        REG_WDOG      = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic        quad_en;
        logic        left_inv;
        logic        right_inv;
        logic        bump_en;
        logic        us_en;
        logic [14:0] stop_echo;
        logic [15:0] wdog_limit;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [15:0] left_percent;
        logic signed [15:0] right_percent;
        logic               phase_b_high;
        logic [14:0]        echo_time_in;
        logic               estop_asserted;
        logic               bumper_left;
        logic               bumper_right;
    } item_t;

    typedef struct packed {
        logic signed [7:0] left_cmd;
        logic signed [7:0] right_cmd;
        logic              left_dir;
        logic              right_dir;
        logic [15:0]       since_ms;
        logic [14:0]       echo_us;
    } drive_state_t;

    typedef struct packed {
        logic [7:0]        left_duty;
        logic              left_forward;
        logic [7:0]        right_duty;
        logic              right_forward;
        logic [31:0]       left_enc_count;
        logic [31:0]       right_enc_count;
        logic signed [7:0] left_now;
        logic signed [7:0] right_now;
        logic              obstacle_seen;
        logic              watchdog_expired;
    } result_t;

endpackage

>>> rtl/ddsc_cfg_regs.sv
`timescale 1ns / 1ps

module ddsc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [ddsc_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [ddsc_pkg::CFG_DATA_W-1:0]  wr_data,
    output ddsc_pkg::cfg_t                  cfg
);
    import ddsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_QUAD:      cfg_next.quad_en    = wr_data[0];
                REG_LEFT_INV:  cfg_next.left_inv   = wr_data[0];
                REG_RIGHT_INV: cfg_next.right_inv  = wr_data[0];
                REG_BUMP_EN:   cfg_next.bump_en    = wr_data[0];
                REG_US_EN:     cfg_next.us_en      = wr_data[0];
                REG_STOP_ECHO: cfg_next.stop_echo  = wr_data[14:0];
                REG_WDOG:      cfg_next.wdog_limit = wr_data[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quad_en    <= 1'b0;
            cfg_reg.left_inv   <= 1'b0;
            cfg_reg.right_inv  <= 1'b0;
            cfg_reg.bump_en    <= 1'b0;
            cfg_reg.us_en      <= 1'b0;
            cfg_reg.stop_echo  <= STOP_ECHO_RESET;
            cfg_reg.wdog_limit <= WDOG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/ddsc_step.sv
`timescale 1ns / 1ps

module ddsc_step #(
    parameter int COUNT_BITS = ddsc_pkg::COUNT_BITS_DEF
) (
    input  ddsc_pkg::cfg_t          cfg,
    input  ddsc_pkg::item_t         item,
    input  ddsc_pkg::drive_state_t  st,
    input  logic [COUNT_BITS-1:0]   left_count,
    input  logic [COUNT_BITS-1:0]   right_count,
    output ddsc_pkg::drive_state_t  st_next,
    output logic [COUNT_BITS-1:0]   left_count_next,
    output logic [COUNT_BITS-1:0]   right_count_next,
    output ddsc_pkg::result_t       res
);
    import ddsc_pkg::*;

    function automatic logic signed [7:0] clamp_cmd(input logic signed [15:0] v);
        logic signed [7:0] r;
        if (v > CMD_LIMIT)
            r = 8'(CMD_LIMIT);
        else if (v < -CMD_LIMIT)
            r = -8'(CMD_LIMIT);
        else
            r = 8'(v);
        return r;
    endfunction

    function automatic logic [7:0] duty_of(input logic signed [7:0] cmd);
        logic [6:0]  mag;
        logic [14:0] scaled;
        logic [27:0] prod;
        mag    = cmd[7] ? 7'(-cmd) : 7'(cmd);
        scaled = (15'(mag) << 8) - 15'(mag);
        prod   = 28'(scaled) * 28'(DUTY_RECIP);
        return 8'(prod >> DUTY_SHIFT);
    endfunction

    function automatic logic [COUNT_BITS-1:0] count_step(
        input logic [COUNT_BITS-1:0] count,
        input logic signed [7:0]     cmd,
        input logic                  b_high,
        input logic                  inv,
        input logic                  quad
    );
        logic up;
        logic dn;
        logic [COUNT_BITS-1:0] r;
        if (quad)
        begin
            up = !b_high;
            dn = b_high;
        end
        else
        begin
            up = (cmd > 8'sd0);
            dn = cmd[7];
        end
        r = count;
        if (inv ? dn : up)
            r = count + COUNT_BITS'(1);
        else if (inv ? up : dn)
            r = count - COUNT_BITS'(1);
        return r;
    endfunction

    logic signed [7:0] left_clamped;
    logic signed [7:0] right_clamped;
    logic signed [8:0] drive_sum;
    logic signed [8:0] after_sum;
    logic              obstacle;
    logic              expired;

    assign left_clamped  = clamp_cmd(item.left_percent);
    assign right_clamped = clamp_cmd(item.right_percent);
    assign drive_sum     = 9'(left_clamped) + 9'(right_clamped);

    always_comb
    begin
        st_next          = st;
        left_count_next  = left_count;
        right_count_next = right_count;

        if (item.mode == MODE_ECHO)
            st_next.echo_us = item.echo_time_in;

        obstacle = (cfg.bump_en && (item.bumper_left || item.bumper_right)) ||
                   (cfg.us_en && (st_next.echo_us != 15'd0) &&
                    (st_next.echo_us <= cfg.stop_echo));

        case (item.mode)
            MODE_DRIVE:
            begin
                if (item.estop_asserted || (drive_sum > 9'sd0 && obstacle))
                begin
                    st_next.left_cmd  = 8'sd0;
                    st_next.right_cmd = 8'sd0;
                end
                else
                begin
                    st_next.left_cmd  = left_clamped;
                    st_next.right_cmd = right_clamped;
                    st_next.left_dir  = !left_clamped[7];
                    st_next.right_dir = !right_clamped[7];
                end
                st_next.since_ms = 16'd0;
            end
            MODE_STOP:
            begin
                st_next.left_cmd  = 8'sd0;
                st_next.right_cmd = 8'sd0;
                st_next.since_ms  = 16'd0;
            end
            MODE_CLEAR:
            begin
                left_count_next  = '0;
                right_count_next = '0;
                st_next.since_ms = 16'd0;
            end
            MODE_TICK:
            begin
                if (st.since_ms != SINCE_MAX)
                    st_next.since_ms = st.since_ms + 16'd1;
            end
            MODE_LEFT:
                left_count_next = count_step(left_count, st.left_cmd, item.phase_b_high,
                                             cfg.left_inv, cfg.quad_en);
            MODE_RIGHT:
                right_count_next = count_step(right_count, st.right_cmd, item.phase_b_high,
                                              cfg.right_inv, cfg.quad_en);
            default:
            begin
                st_next.since_ms = st_next.since_ms;
            end
        endcase

        // after-item interlocks
        expired = st_next.since_ms > cfg.wdog_limit;
        if (expired || item.estop_asserted)
        begin
            st_next.left_cmd  = 8'sd0;
            st_next.right_cmd = 8'sd0;
        end
        after_sum = 9'(st_next.left_cmd) + 9'(st_next.right_cmd);
        if (after_sum > 9'sd0 && obstacle)
        begin
            st_next.left_cmd  = 8'sd0;
            st_next.right_cmd = 8'sd0;
        end
    end

    always_comb
    begin
        res.left_duty        = duty_of(st_next.left_cmd);
        res.left_forward     = st_next.left_dir;
        res.right_duty       = duty_of(st_next.right_cmd);
        res.right_forward    = st_next.right_dir;
        res.left_enc_count   = 32'(left_count_next);
        res.right_enc_count  = 32'(right_count_next);
        res.left_now         = st_next.left_cmd;
        res.right_now        = st_next.right_cmd;
        res.obstacle_seen    = obstacle;
        res.watchdog_expired = expired;
    end

endmodule

>>> rtl/diff_drive_safety_controller.sv
`timescale 1ns / 1ps
// channel   | direction | handshake                   | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata item fields, tuser mode
// m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata result fields
// cfg       | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// one word accepted per cycle while s_axis_tready is high; its result is offered on m_axis after passing
// through the input register, then the result register, with one combinational step between
// rst_n clears wheel commands, counts, watchdog, echo time and config to defaults
// s_axis_tready falls only while both registers are full and m_axis_tready is low
// cfg_ready is always high; a write is registered and lands in the next cycle

`include "diff_drive_safety_controller_defines.svh"

module diff_drive_safety_controller #(
    parameter int COUNT_BITS = ddsc_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // left_percent[15:0], right_percent[31:16], phase_b_high[32], echo_time_in[47:33],
    // estop_asserted[48], bumper_left[49], bumper_right[50], zero pad[55:51]
    input  logic [ddsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[2:0]
    input  logic [ddsc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // left_duty[7:0], left_forward[8], right_duty[16:9], right_forward[17],
    // left_enc_count[49:18], right_enc_count[81:50], left_now[89:82], right_now[97:90],
    // obstacle_seen[98], watchdog_expired[99], zero pad[103:100]
    output logic [ddsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ddsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ddsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ddsc_pkg::*;

    cfg_t                  cfg;
    item_t                 item_in;
    item_t                 item_reg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               result_reg;
    result_t               result_next;
    drive_state_t          st_reg;
    drive_state_t          st_next;
    logic [COUNT_BITS-1:0] left_count_reg;
    logic [COUNT_BITS-1:0] left_count_next;
    logic [COUNT_BITS-1:0] right_count_reg;
    logic [COUNT_BITS-1:0] right_count_next;
    logic                  in_fire;
    logic                  advance;

    assign cfg_ready = 1'b1;

    ddsc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign item_in.mode           = mode_t'(s_axis_tuser);
    assign item_in.left_percent   = s_axis_tdata[15:0];
    assign item_in.right_percent  = s_axis_tdata[31:16];
    assign item_in.phase_b_high   = s_axis_tdata[32];
    assign item_in.echo_time_in   = s_axis_tdata[47:33];
    assign item_in.estop_asserted = s_axis_tdata[48];
    assign item_in.bumper_left    = s_axis_tdata[49];
    assign item_in.bumper_right   = s_axis_tdata[50];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    ddsc_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .cfg              (cfg),
        .item             (item_reg),
        .st               (st_reg),
        .left_count       (left_count_reg),
        .right_count      (right_count_reg),
        .st_next          (st_next),
        .left_count_next  (left_count_next),
        .right_count_next (right_count_next),
        .res              (result_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            st_reg          <= '0;
            left_count_reg  <= '0;
            right_count_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg          <= st_next;
                left_count_reg  <= left_count_next;
                right_count_reg <= right_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= item_in;
        if (advance)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0,
                            result_reg.watchdog_expired,
                            result_reg.obstacle_seen,
                            result_reg.right_now,
                            result_reg.left_now,
                            result_reg.right_enc_count,
                            result_reg.left_enc_count,
                            result_reg.right_forward,
                            result_reg.right_duty,
                            result_reg.left_forward,
                            result_reg.left_duty};

    `DDSC_ASSERT_NEXT(a_item_kept, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    `DDSC_ASSERT_NEXT(a_estop_stops, clk, rst_n, advance && item_reg.estop_asserted,
        result_reg.left_now == 8'sd0 && result_reg.right_now == 8'sd0)
    `DDSC_ASSERT_NOW(a_wdog_stops, clk, rst_n, out_valid_reg && result_reg.watchdog_expired,
        result_reg.left_now == 8'sd0 && result_reg.right_now == 8'sd0)
    `DDSC_ASSERT_NOW(a_duty_matches, clk, rst_n, out_valid_reg,
        (result_reg.left_duty == 8'd0) == (result_reg.left_now == 8'sd0))
    `DDSC_ASSERT_NOW(a_no_forward_hit, clk, rst_n, out_valid_reg && result_reg.obstacle_seen,
        (9'(result_reg.left_now) + 9'(result_reg.right_now)) <= 9'sd0)

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import ddsc_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam logic [2:0] REG_NONE    = 3'd7;
    localparam int         PHASE_WORDS = 244;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] left_pct;
        logic signed [15:0] right_pct;
        logic               b_high;
        logic [14:0]        echo;
        logic               estop;
        logic               bump_l;
        logic               bump_r;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0]        l_duty;
        logic              l_fwd;
        logic [7:0]        r_duty;
        logic              r_fwd;
        logic [31:0]       l_ticks;
        logic [31:0]       r_ticks;
        logic signed [7:0] l_now;
        logic signed [7:0] r_now;
        logic              obstacle;
        logic              expired;
    } wheel_status_t;

    typedef struct packed {
        logic          is_cfg;
        logic [2:0]    reg_idx;
        logic [15:0]   reg_val;
        cmd_word_t     word;
        logic          typed;
        wheel_status_t want;
    } script_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // controller settings as the block should hold them
    logic        cfg_quad = 1'b0;
    logic        cfg_left_inv = 1'b0;
    logic        cfg_right_inv = 1'b0;
    logic        cfg_bump = 1'b0;
    logic        cfg_sonar = 1'b0;
    logic [14:0] cfg_stop_echo = STOP_ECHO_RESET;
    logic [15:0] cfg_wdog = WDOG_RESET;

    // controller state as the block should hold it
    logic signed [7:0] left_cmd = '0;
    logic signed [7:0] right_cmd = '0;
    logic              left_dir = 1'b0;
    logic              right_dir = 1'b0;
    logic [31:0]       left_count = '0;
    logic [31:0]       right_count = '0;
    logic [15:0]       since_ms = '0;
    logic [14:0]       echo_us = '0;

    wheel_status_t status_due[$];
    script_row_t   script[$];
    int            mismatches = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;

    diff_drive_safety_controller u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [7:0] clamp_pct(input logic signed [15:0] v);
        if (v > CMD_LIMIT)
            return 8'sd100;
        if (v < -CMD_LIMIT)
            return -8'sd100;
        return v[7:0];
    endfunction

    function automatic logic [7:0] duty_of_cmd(input logic signed [7:0] c);
        int mag;
        mag = (c < 0) ? -int'(c) : int'(c);
        return 8'(mag * 255 / 100);
    endfunction

    function automatic logic [31:0] step_count(input logic [31:0] cnt,
                                               input logic signed [7:0] cmd,
                                               input logic b_high, input logic inv);
        int dir;
        if (cfg_quad)
            dir = b_high ? -1 : 1;
        else
            dir = (cmd > 0) ? 1 : ((cmd < 0) ? -1 : 0);
        if (inv)
            dir = -dir;
        return cnt + 32'(dir);
    endfunction

    function automatic wheel_status_t advance_controller(input cmd_word_t w);
        logic signed [7:0] lc;
        logic signed [7:0] rc;
        logic              near;
        logic              expired;
        wheel_status_t     s;
        if (w.mode == MODE_ECHO)
            echo_us = w.echo;
        near = (cfg_bump && (w.bump_l || w.bump_r))
            || (cfg_sonar && echo_us != 0 && echo_us <= cfg_stop_echo);
        lc = clamp_pct(w.left_pct);
        rc = clamp_pct(w.right_pct);
        case (w.mode)
            MODE_DRIVE:
            begin
                if (w.estop || (int'(lc) + int'(rc) > 0 && near))
                begin
                    left_cmd = '0;
                    right_cmd = '0;
                end
                else
                begin
                    left_cmd = lc;
                    right_cmd = rc;
                    left_dir = (lc >= 0);
                    right_dir = (rc >= 0);
                end
                since_ms = '0;
            end
            MODE_STOP:
            begin
                left_cmd = '0;
                right_cmd = '0;
                since_ms = '0;
            end
            MODE_CLEAR:
            begin
                left_count = '0;
                right_count = '0;
                since_ms = '0;
            end
            MODE_TICK:
            begin
                if (since_ms != SINCE_MAX)
                    since_ms = since_ms + 16'd1;
            end
            MODE_LEFT:
                left_count = step_count(left_count, left_cmd, w.b_high, cfg_left_inv);
            MODE_RIGHT:
                right_count = step_count(right_count, right_cmd, w.b_high, cfg_right_inv);
            default:
            begin
            end
        endcase
        expired = (since_ms > cfg_wdog);
        // safety pass after every word
        if (expired || w.estop || (int'(left_cmd) + int'(right_cmd) > 0 && near))
        begin
            left_cmd = '0;
            right_cmd = '0;
        end
        s.l_duty = duty_of_cmd(left_cmd);
        s.l_fwd = left_dir;
        s.r_duty = duty_of_cmd(right_cmd);
        s.r_fwd = right_dir;
        s.l_ticks = left_count;
        s.r_ticks = right_count;
        s.l_now = left_cmd;
        s.r_now = right_cmd;
        s.obstacle = near;
        s.expired = expired;
        return s;
    endfunction

    function automatic script_row_t op(input logic [2:0] m, input int lp, input int rp,
                                       input logic b, input int echo, input logic es,
                                       input logic bl, input logic br);
        script_row_t r;
        r = '0;
        r.word.mode = m;
        r.word.left_pct = 16'(lp);
        r.word.right_pct = 16'(rp);
        r.word.b_high = b;
        r.word.echo = 15'(echo);
        r.word.estop = es;
        r.word.bump_l = bl;
        r.word.bump_r = br;
        return r;
    endfunction

    function automatic script_row_t reg_w(input logic [2:0] idx, input logic [15:0] val);
        script_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int        pick;
        int        near_val;
        pick = $urandom_range(99);
        if (pick < 25)
            w.mode = MODE_DRIVE;
        else if (pick < 30)
            w.mode = MODE_STOP;
        else if (pick < 34)
            w.mode = MODE_CLEAR;
        else if (pick < 60)
            w.mode = MODE_TICK;
        else if (pick < 73)
            w.mode = MODE_LEFT;
        else if (pick < 86)
            w.mode = MODE_RIGHT;
        else if (pick < 98)
            w.mode = MODE_ECHO;
        else
            w.mode = MODE_UNUSED;
        if ($urandom_range(9) == 0)
            w.left_pct = 16'($urandom);
        else
            w.left_pct = 16'(int'($urandom_range(240)) - 120);
        if ($urandom_range(9) == 0)
            w.right_pct = 16'($urandom);
        else
            w.right_pct = 16'(int'($urandom_range(240)) - 120);
        w.b_high = 1'($urandom);
        pick = $urandom_range(9);
        near_val = int'(cfg_stop_echo) + int'($urandom_range(6)) - 3;
        if (near_val < 0)
            near_val = 0;
        if (pick == 0)
            w.echo = '0;
        else if (pick <= 5)
            w.echo = 15'(near_val);
        else if (pick <= 8)
            w.echo = 15'($urandom_range(25000));
        else
            w.echo = 15'($urandom_range(32767));
        w.estop = ($urandom_range(19) == 0);
        w.bump_l = ($urandom_range(7) == 0);
        w.bump_r = ($urandom_range(7) == 0);
        return w;
    endfunction

    task automatic report(input string msg);
        if (mismatches < 200)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic send_word(input cmd_word_t w, input logic typed,
                             input wheel_status_t want);
        wheel_status_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= w.mode;
        s_axis_tdata <= {5'b0, w.bump_r, w.bump_l, w.estop, w.echo, w.b_high,
                         w.right_pct, w.left_pct};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = advance_controller(w);
        status_due.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_QUAD:      cfg_quad = val[0];
            REG_LEFT_INV:  cfg_left_inv = val[0];
            REG_RIGHT_INV: cfg_right_inv = val[0];
            REG_BUMP_EN:   cfg_bump = val[0];
            REG_US_EN:     cfg_sonar = val[0];
            REG_STOP_ECHO: cfg_stop_echo = val[14:0];
            REG_WDOG:      cfg_wdog = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic load_settings(input logic quad, input logic linv, input logic rinv,
                                 input logic bump, input logic sonar,
                                 input logic [14:0] stop_echo, input logic [15:0] wdog);
        drain_results(4);
        // junk in the unused upper bits must be dropped
        cfg_write(REG_QUAD, {15'($urandom), quad});
        cfg_write(REG_LEFT_INV, {15'($urandom), linv});
        cfg_write(REG_RIGHT_INV, {15'($urandom), rinv});
        cfg_write(REG_BUMP_EN, {15'($urandom), bump});
        cfg_write(REG_US_EN, {15'($urandom), sonar});
        cfg_write(REG_STOP_ECHO, {1'($urandom), stop_echo});
        cfg_write(REG_WDOG, wdog);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        wheel_status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (status_due.size() == 0)
                report("result word with nothing outstanding");
            else
            begin
                want = status_due.pop_front();
                check_field("left_duty", 32'(m_axis_tdata[7:0]), 32'(want.l_duty));
                check_field("left_forward", 32'(m_axis_tdata[8]), 32'(want.l_fwd));
                check_field("right_duty", 32'(m_axis_tdata[16:9]), 32'(want.r_duty));
                check_field("right_forward", 32'(m_axis_tdata[17]), 32'(want.r_fwd));
                check_field("left_enc_count", m_axis_tdata[49:18], want.l_ticks);
                check_field("right_enc_count", m_axis_tdata[81:50], want.r_ticks);
                check_field("left_now", 32'(m_axis_tdata[89:82]), 32'(unsigned'(want.l_now)));
                check_field("right_now", 32'(m_axis_tdata[97:90]), 32'(unsigned'(want.r_now)));
                check_field("obstacle_seen", 32'(m_axis_tdata[98]), 32'(want.obstacle));
                check_field("watchdog_expired", 32'(m_axis_tdata[99]), 32'(want.expired));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #400000;
        $display("** diff_drive_safety_controller: FAILED **");
        $finish;
    end

    initial
    begin
        script_row_t row;

        // defaults after reset
        row = op(MODE_TICK, 0, 0, 0, 0, 0, 0, 0);
        row.typed = 1'b1;
        row.want = '0;
        script.push_back(row);
        row = op(MODE_DRIVE, 32767, -32768, 0, 0, 0, 0, 0);
        row.typed = 1'b1;
        row.want = '{8'd255, 1'b1, 8'd255, 1'b0, 32'd0, 32'd0, 8'sd100, -8'sd100,
                     1'b0, 1'b0};
        script.push_back(row);
        script.push_back(op(MODE_LEFT, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(op(MODE_RIGHT, 0, 0, 1, 0, 0, 0, 0));
        script.push_back(op(MODE_DRIVE, 0, 0, 0, 0, 0, 0, 0));
        // edge with no command leaves the count alone
        script.push_back(op(MODE_LEFT, 0, 0, 1, 0, 0, 0, 0));
        script.push_back(op(MODE_DRIVE, -1, 1, 0, 0, 0, 0, 0));
        script.push_back(op(MODE_UNUSED, 0, 0, 1, 32767, 0, 1, 1));
        script.push_back(op(MODE_DRIVE, 50, 50, 0, 0, 1, 0, 0));
        script.push_back(op(MODE_STOP, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(op(MODE_ECHO, 0, 0, 0, 32767, 0, 0, 0));
        script.push_back(op(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        // quadrature, interlocks on, watchdog limit zero
        script.push_back(reg_w(REG_NONE, 16'hFFFF));
        script.push_back(reg_w(REG_QUAD, 16'd1));
        script.push_back(reg_w(REG_LEFT_INV, 16'd1));
        script.push_back(reg_w(REG_BUMP_EN, 16'd1));
        script.push_back(reg_w(REG_US_EN, 16'd1));
        script.push_back(reg_w(REG_STOP_ECHO, 16'hFFFF));
        script.push_back(reg_w(REG_WDOG, 16'd0));
        script.push_back(op(MODE_ECHO, 0, 0, 0, 100, 0, 0, 0));
        script.push_back(op(MODE_DRIVE, 60, -20, 0, 0, 0, 0, 0));
        script.push_back(op(MODE_DRIVE, -60, 20, 0, 0, 0, 0, 0));
        script.push_back(op(MODE_LEFT, 0, 0, 1, 0, 0, 0, 0));
        script.push_back(op(MODE_RIGHT, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(op(MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        // watchdog never expires, echo threshold zero
        script.push_back(reg_w(REG_WDOG, 16'hFFFF));
        script.push_back(reg_w(REG_STOP_ECHO, 16'd0));
        script.push_back(op(MODE_DRIVE, 100, 100, 0, 0, 0, 1, 0));
        script.push_back(op(MODE_DRIVE, 100, 100, 0, 0, 0, 0, 0));
        script.push_back(op(MODE_TICK, 0, 0, 0, 0, 0, 0, 1));
        script.push_back(op(MODE_ECHO, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(reg_w(REG_QUAD, 16'd0));
        script.push_back(reg_w(REG_RIGHT_INV, 16'd1));
        script.push_back(op(MODE_DRIVE, 30, -100, 0, 0, 0, 0, 0));
        script.push_back(op(MODE_RIGHT, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(op(MODE_LEFT, 0, 0, 1, 0, 0, 0, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain_results(4);
                cfg_write(script[i].reg_idx, script[i].reg_val);
                cfg_valid <= 1'b0;
            end
            else
                send_word(script[i].word, script[i].typed, script[i].want);
        end

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: load_settings(0, 0, 0, 1, 1, 15'd2040, 16'd6);
                1: load_settings(1, 1, 0, 0, 1, 15'd0, 16'd1);
                2: load_settings(1, 0, 1, 1, 0, 15'd25000, 16'd65534);
                3: load_settings(0, 1, 1, 1, 1, 15'h7FFF, 16'd0);
                default: load_settings(1'($urandom), 1'($urandom), 1'($urandom),
                                       1'($urandom), 1'($urandom),
                                       15'($urandom_range(25000)),
                                       16'($urandom_range(40, 2)));
            endcase
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 74;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 74;
                end
                default:
                begin
                    idle_pct = 27;
                    stall_pct = 27;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // now and then hold off until the pipeline is empty
                if ($urandom_range(199) == 0)
                    drain_results(0);
                send_word(random_word(), 1'b0, '0);
            end
        end

        drain_results(8);
        if (mismatches == 0)
            $display("** diff_drive_safety_controller: PASSED **");
        else
            $display("** diff_drive_safety_controller: FAILED **");
        $finish;
    end

endmodule
